FILE: design/shape_raster_framebuffer_defines.svh
// Assertion macros shared by the frame buffer design.
`ifndef SHAPE_RASTER_FRAMEBUFFER_DEFINES_SVH
`define SHAPE_RASTER_FRAMEBUFFER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/srf_pkg.sv
package srf_pkg;

    localparam int FRAME_WIDTH  = 800;
    localparam int FRAME_HEIGHT = 600;
    localparam int PIX_COUNT    = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W       = $clog2(PIX_COUNT);

    localparam int CMD_W = 3;
    localparam int FLD_W = 10;
    localparam int PIX_W = 24;
    localparam int CH_W  = 8;
    localparam int BW_W  = 5;

    localparam logic [BW_W-1:0] BW_RESET = 5'd3;
    localparam logic [PIX_W-1:0] PIX_BLACK = 24'h000000;

    localparam int ROW_W = $clog2(FRAME_HEIGHT);
    localparam int COL_W = $clog2(FRAME_WIDTH);
    localparam int DIM_W = (ROW_W > COL_W) ? ROW_W : COL_W;
    // Signed coordinate width: holds a centre plus or minus a radius.
    localparam int SC_W  = ((DIM_W > FLD_W) ? DIM_W : FLD_W) + 2;
    // Width of a sum of two squared offsets.
    localparam int SQ_W  = 2 * FLD_W + 1;

    localparam logic signed [SC_W-1:0] SC_ZERO = '0;
    localparam logic signed [SC_W-1:0] H_S = SC_W'(FRAME_HEIGHT);
    localparam logic signed [SC_W-1:0] W_S = SC_W'(FRAME_WIDTH);

    typedef enum logic [CMD_W-1:0] {
        CMD_FILL = 3'd0,
        CMD_RECT = 3'd1,
        CMD_DISC = 3'd2,
        CMD_RING = 3'd3,
        CMD_READ = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_DRAW,
        ST_RDATA,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        RS_IDLE,
        RS_SQR,
        RS_SQI,
        RS_RUN
    } t_rstate;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [FLD_W-1:0] row;
        logic [FLD_W-1:0] col;
        logic [FLD_W-1:0] row_end;
        logic [FLD_W-1:0] col_end;
        logic [FLD_W-1:0] radius;
        logic [FLD_W-1:0] ring_width;
        logic [PIX_W-1:0] color;
    } t_req;

    typedef struct packed {
        t_cmd                    mode;
        logic signed [SC_W-1:0]  r0;
        logic signed [SC_W-1:0]  c0;
        logic signed [SC_W-1:0]  r1;
        logic signed [SC_W-1:0]  c1;
        logic [FLD_W-1:0]        rad;
        logic signed [SC_W-1:0]  rin;
        logic [BW_W-1:0]         bw;
        logic [PIX_W-1:0]        color;
    } t_rast_job;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
    } t_mem_wr;

    function automatic logic signed [SC_W-1:0] to_sc(input logic [FLD_W-1:0] v);
        return $signed({{(SC_W-FLD_W){1'b0}}, v});
    endfunction

    // Difference between the squares of d+1 and d.
    function automatic logic [SQ_W-1:0] sq_step(input logic signed [SC_W-1:0] d);
        logic signed [SC_W:0] t;
        t = {d, 1'b1};
        return SQ_W'(t);
    endfunction

endpackage

FILE: design/srf_if.sv
interface srf_cmd_if import srf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [FLD_W-1:0] row;
    logic [FLD_W-1:0] col;
    logic [FLD_W-1:0] row_end;
    logic [FLD_W-1:0] col_end;
    logic [FLD_W-1:0] radius;
    logic [FLD_W-1:0] ring_width;
    logic [PIX_W-1:0] color;

    modport source (
        output valid, cmd, row, col, row_end, col_end, radius, ring_width, color,
        input  ready
    );
    modport sink (
        input  valid, cmd, row, col, row_end, col_end, radius, ring_width, color,
        output ready
    );
endinterface

interface srf_rsp_if import srf_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            status;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;

    modport source (
        output valid, status, red, green, blue,
        input  ready
    );
    modport sink (
        input  valid, status, red, green, blue,
        output ready
    );
endinterface

FILE: design/srf_ram.sv
module srf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/srf_raster.sv
module srf_raster import srf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_rast_job i_job,
    output logic      o_done,
    output t_mem_wr   o_wr
);

    t_rstate r_state, n_state;
    t_rast_job r_job, n_job;
    logic signed [SC_W-1:0] r_h, n_h, r_c, n_c, r_dh, n_dh, r_dc, n_dc;
    logic signed [SC_W-1:0] r_lim_r0, n_lim_r0, r_lim_r1, n_lim_r1;
    logic signed [SC_W-1:0] r_lim_c0, n_lim_c0, r_lim_c1, n_lim_c1;
    logic [SQ_W-1:0] r_sqh, n_sqh, r_sqc, n_sqc, r_rr, n_rr, r_rri, n_rri;
    logic r_inner, n_inner;
    logic [ADDR_W-1:0] r_addr, n_addr, r_step, n_step;

    logic [FLD_W-1:0] w_mul_a;
    logic [2*FLD_W-1:0] w_sq;
    logic signed [SC_W-1:0] w_bw_s, w_neg_rad;
    logic [SQ_W-1:0] w_sum;
    logic w_last_col, w_last, w_rect_hit, w_outer, w_in_hole;

    assign w_mul_a   = (r_state == RS_SQI) ? r_job.rin[FLD_W-1:0] : r_job.rad;
    assign w_sq      = w_mul_a * w_mul_a;
    assign w_bw_s    = $signed({{(SC_W-BW_W){1'b0}}, r_job.bw});
    assign w_neg_rad = SC_ZERO - to_sc(r_job.rad);

    assign w_sum      = r_sqh + r_sqc;
    assign w_outer    = w_sum < r_rr;
    assign w_in_hole  = r_inner && (w_sum < r_rri);
    assign w_rect_hit = (r_c < r_lim_c0) || (r_c > r_lim_c1) ||
                        (r_h < r_lim_r0) || (r_h > r_lim_r1);
    assign w_last_col = r_c == r_job.c1;
    assign w_last     = w_last_col && (r_h == r_job.r1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            RS_IDLE: begin
                if (i_start) begin
                    n_state = RS_SQR;
                end
            end
            RS_SQR: n_state = RS_SQI;
            RS_SQI: n_state = RS_RUN;
            RS_RUN: begin
                if (w_last) begin
                    n_state = RS_IDLE;
                end
            end
            default: n_state = RS_IDLE;
        endcase
    end

    always_comb begin
        o_wr.en   = 1'b0;
        o_wr.addr = r_addr;
        o_wr.data = w_in_hole ? PIX_BLACK : r_job.color;
        o_done    = 1'b0;
        if (r_state == RS_RUN) begin
            o_done = w_last;
            case (r_job.mode)
                CMD_FILL: o_wr.en = 1'b1;
                CMD_RECT: o_wr.en = w_rect_hit;
                CMD_DISC, CMD_RING: o_wr.en = w_outer;
                default: o_wr.en = 1'b0;
            endcase
        end
    end

    always_comb begin
        n_job    = r_job;
        n_h      = r_h;
        n_c      = r_c;
        n_dh     = r_dh;
        n_dc     = r_dc;
        n_lim_r0 = r_lim_r0;
        n_lim_r1 = r_lim_r1;
        n_lim_c0 = r_lim_c0;
        n_lim_c1 = r_lim_c1;
        n_sqh    = r_sqh;
        n_sqc    = r_sqc;
        n_rr     = r_rr;
        n_rri    = r_rri;
        n_inner  = r_inner;
        n_addr   = r_addr;
        n_step   = r_step;
        case (r_state)
            RS_IDLE: begin
                if (i_start) begin
                    n_job = i_job;
                end
            end
            RS_SQR: begin
                n_rr     = SQ_W'(w_sq);
                n_inner  = r_job.rin > SC_ZERO;
                n_h      = r_job.r0;
                n_c      = r_job.c0;
                n_dh     = w_neg_rad;
                n_dc     = w_neg_rad;
                n_lim_r0 = r_job.r0 + w_bw_s;
                n_lim_r1 = r_job.r1 - w_bw_s;
                n_lim_c0 = r_job.c0 + w_bw_s;
                n_lim_c1 = r_job.c1 - w_bw_s;
                n_addr   = ADDR_W'($unsigned(r_job.r0)) * ADDR_W'(FRAME_WIDTH)
                           + ADDR_W'($unsigned(r_job.c0));
                n_step   = ADDR_W'(FRAME_WIDTH)
                           - ADDR_W'($unsigned(r_job.c1 - r_job.c0));
            end
            RS_SQI: begin
                n_rri = SQ_W'(w_sq);
                n_sqh = r_rr;
                n_sqc = r_rr;
            end
            RS_RUN: begin
                if (w_last_col) begin
                    n_h    = r_h + SC_W'(1);
                    n_c    = r_job.c0;
                    n_dh   = r_dh + SC_W'(1);
                    n_dc   = w_neg_rad;
                    n_sqh  = r_sqh + sq_step(r_dh);
                    n_sqc  = r_rr;
                    n_addr = r_addr + r_step;
                end else begin
                    n_c    = r_c + SC_W'(1);
                    n_dc   = r_dc + SC_W'(1);
                    n_sqc  = r_sqc + sq_step(r_dc);
                    n_addr = r_addr + ADDR_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job    <= n_job;
        r_h      <= n_h;
        r_c      <= n_c;
        r_dh     <= n_dh;
        r_dc     <= n_dc;
        r_lim_r0 <= n_lim_r0;
        r_lim_r1 <= n_lim_r1;
        r_lim_c0 <= n_lim_c0;
        r_lim_c1 <= n_lim_c1;
        r_sqh    <= n_sqh;
        r_sqc    <= n_sqc;
        r_rr     <= n_rr;
        r_rri    <= n_rri;
        r_inner  <= n_inner;
        r_addr   <= n_addr;
        r_step   <= n_step;
    end

endmodule

FILE: design/shape_raster_framebuffer.sv
// Shape rasterizer over an 800 by 600 frame store of 24-bit RGB pixels.
// Commands arrive on the i_cmd channel and each produces exactly one item on
// the o_rsp channel, in order: status, and for a pixel read its red, green
// and blue. The i_cfg_we and i_cfg_data port sets the rectangle border width.
// The store is one single-port-write memory with a registered read. A drawing
// command walks its bounding box one pixel per cycle, after the set-up states
// RS_SQR and RS_SQI that square the radii; a fill walks the whole frame. Disc
// and ring tests use running squares, so the walk never stalls. A pixel read
// passes ST_CHECK, which issues the memory read, and ST_RDATA, which captures
// the data, before ST_DONE loads the result; a rejected or unused command goes
// from ST_CHECK to ST_DONE. Commands are processed one at a time. After reset
// the block runs a clearing pass that writes black to every pixel, with ready
// held low; border width resets to 3. A finished result waits in the output
// register while the receiver stalls; the next command is still accepted and
// processed, and its result is held back until the output register is emptied.
`include "shape_raster_framebuffer_defines.svh"

module shape_raster_framebuffer import srf_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    srf_cmd_if.sink         i_cmd,
    srf_rsp_if.source       o_rsp,
    input  logic            i_cfg_we,
    input  logic [BW_W-1:0] i_cfg_data
);

    t_state r_state, n_state;
    t_req r_req, n_req;
    logic [BW_W-1:0] r_bw, n_bw;
    logic r_status, n_status;
    logic [PIX_W-1:0] r_px, n_px;
    logic r_out_valid, n_out_valid;
    logic r_out_status, n_out_status;
    logic [PIX_W-1:0] r_out_px, n_out_px;

    logic w_accept, w_load, w_start, w_done, w_draw_go, w_rd_en;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [PIX_W-1:0] w_rd_data;
    t_rast_job w_job;
    t_mem_wr w_wr;
    t_cmd w_cmd;
    logic signed [SC_W-1:0] w_row, w_col, w_rend, w_cend, w_rad, w_rw;
    logic signed [SC_W-1:0] w_top, w_bot, w_left, w_right;
    logic w_rect_oob, w_rect_rev, w_fit, w_read_oob;

    assign w_cmd   = t_cmd'(r_req.cmd);
    assign w_row   = to_sc(r_req.row);
    assign w_col   = to_sc(r_req.col);
    assign w_rend  = to_sc(r_req.row_end);
    assign w_cend  = to_sc(r_req.col_end);
    assign w_rad   = to_sc(r_req.radius);
    assign w_rw    = to_sc(r_req.ring_width);
    assign w_top   = w_row - w_rad;
    assign w_bot   = w_row + w_rad;
    assign w_left  = w_col - w_rad;
    assign w_right = w_col + w_rad;

    assign w_rect_oob = (w_row >= H_S) || (w_rend >= H_S) ||
                        (w_col >= W_S) || (w_cend >= W_S);
    assign w_rect_rev = (w_row > w_rend) || (w_col > w_cend);
    assign w_fit      = (w_top >= SC_ZERO) && (w_left >= SC_ZERO) &&
                        (w_bot < H_S) && (w_right < W_S);
    assign w_read_oob = (w_row >= H_S) || (w_col >= W_S);
    assign w_rd_addr  = ADDR_W'(r_req.row) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(r_req.col);

    always_comb begin
        case (w_cmd)
            CMD_FILL: w_draw_go = 1'b1;
            CMD_RECT: w_draw_go = !w_rect_oob && !w_rect_rev;
            CMD_DISC, CMD_RING: w_draw_go = w_fit;
            default: w_draw_go = 1'b0;
        endcase
    end

    assign w_accept = i_cmd.valid && i_cmd.ready;
    assign w_load   = (r_state == ST_DONE) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: n_state = ST_CLEAR;
            ST_CLEAR: begin
                if (w_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (w_draw_go) begin
                    n_state = ST_DRAW;
                end else if (w_cmd == CMD_READ && !w_read_oob) begin
                    n_state = ST_RDATA;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DRAW: begin
                if (w_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_RDATA: n_state = ST_DONE;
            ST_DONE: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_INIT;
        endcase
    end

    always_comb begin
        i_cmd.ready = r_state == ST_IDLE;
        w_start     = (r_state == ST_INIT) || ((r_state == ST_CHECK) && w_draw_go);
        w_rd_en     = (r_state == ST_CHECK) && (w_cmd == CMD_READ) && !w_read_oob;

        w_job.mode  = w_cmd;
        w_job.r0    = SC_ZERO;
        w_job.c0    = SC_ZERO;
        w_job.r1    = H_S - SC_W'(1);
        w_job.c1    = W_S - SC_W'(1);
        w_job.rad   = '0;
        w_job.rin   = SC_ZERO;
        w_job.bw    = r_bw;
        w_job.color = r_req.color;
        if (r_state == ST_INIT) begin
            w_job.mode  = CMD_FILL;
            w_job.color = PIX_BLACK;
        end else begin
            case (w_cmd)
                CMD_RECT: begin
                    w_job.r0 = w_row;
                    w_job.c0 = w_col;
                    w_job.r1 = w_rend;
                    w_job.c1 = w_cend;
                end
                CMD_DISC, CMD_RING: begin
                    w_job.r0  = w_top;
                    w_job.c0  = w_left;
                    w_job.r1  = w_bot;
                    w_job.c1  = w_right;
                    w_job.rad = r_req.radius;
                    if (w_cmd == CMD_RING) begin
                        w_job.rin = w_rad - w_rw;
                    end
                end
                default: ;
            endcase
        end

        o_rsp.valid  = r_out_valid;
        o_rsp.status = r_out_status;
        o_rsp.red    = r_out_px[3*CH_W-1:2*CH_W];
        o_rsp.green  = r_out_px[2*CH_W-1:CH_W];
        o_rsp.blue   = r_out_px[CH_W-1:0];
    end

    always_comb begin
        n_req        = r_req;
        n_bw         = i_cfg_we ? i_cfg_data : r_bw;
        n_status     = r_status;
        n_px         = r_px;
        n_out_status = r_out_status;
        n_out_px     = r_out_px;
        n_out_valid  = (r_out_valid && !o_rsp.ready) || w_load;
        if (w_accept) begin
            n_req.cmd        = i_cmd.cmd;
            n_req.row        = i_cmd.row;
            n_req.col        = i_cmd.col;
            n_req.row_end    = i_cmd.row_end;
            n_req.col_end    = i_cmd.col_end;
            n_req.radius     = i_cmd.radius;
            n_req.ring_width = i_cmd.ring_width;
            n_req.color      = i_cmd.color;
        end
        if (r_state == ST_CHECK) begin
            n_px = '0;
            case (w_cmd)
                CMD_RECT: n_status = w_rect_oob;
                CMD_DISC, CMD_RING: n_status = !w_fit;
                CMD_READ: n_status = w_read_oob;
                default: n_status = 1'b0;
            endcase
        end
        if (r_state == ST_RDATA) begin
            n_px = w_rd_data;
        end
        if (w_load) begin
            n_out_status = r_status;
            n_out_px     = r_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_bw        <= BW_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bw        <= n_bw;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_status     <= n_status;
        r_px         <= n_px;
        r_out_status <= n_out_status;
        r_out_px     <= n_out_px;
    end

    srf_raster u_raster (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_job   (w_job),
        .o_done  (w_done),
        .o_wr    (w_wr)
    );

    srf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (PIX_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr.en),
        .i_waddr (w_wr.addr),
        .i_wdata (w_wr.data),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    `SRF_ASSERT_SAME(a_wr_only_drawing, i_clk, i_rst_n, w_wr.en,
        (r_state == ST_DRAW) || (r_state == ST_CLEAR), "pixel write outside a drawing pass")
    `SRF_ASSERT_SAME(a_done_when_waiting, i_clk, i_rst_n, w_done,
        (r_state == ST_DRAW) || (r_state == ST_CLEAR), "raster finished while not awaited")
    `SRF_ASSERT_NEXT(a_read_then_data, i_clk, i_rst_n, w_rd_en,
        r_state == ST_RDATA, "pixel read not followed by data capture")
    `SRF_ASSERT_NEXT(a_load_sets_valid, i_clk, i_rst_n, w_load,
        r_out_valid && (r_state == ST_IDLE), "result load did not present an item")

endmodule

FILE: test/tb_shape_raster_framebuffer.sv
module tb_shape_raster_framebuffer;
    timeunit 1ns;
    timeprecision 1ps;
    import srf_pkg::*;

    localparam int FLD_MAX = (1 << FLD_W) - 1;
    localparam int RANDOM_PER_PHASE = 15;
    localparam int STALL_CYCLES = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = CMD_W'(CMD_READ + 1);
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST = '1;
    localparam logic [BW_W-1:0] BORDER_PLAN [5] = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd7};

    typedef struct packed {
        logic            status;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pixel_reply;

    logic            clk;
    logic            rst_n;
    logic            cfg_we;
    logic [BW_W-1:0] cfg_data;

    srf_cmd_if cmd_ch ();
    srf_rsp_if rsp_ch ();

    shape_raster_framebuffer i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cmd      (cmd_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    bit [PIX_W-1:0]  shadow_fb [PIX_COUNT];
    logic [BW_W-1:0] shadow_bw = BW_RESET;

    t_req         command_backlog [$];
    t_pixel_reply expected_replies [$];
    t_req         next_cmd;
    t_req         seen_cmd;
    t_pixel_reply want;

    bit cmd_taken;
    bit rsp_taken;
    bit no_idle;
    bit stall_request;
    int send_wait;
    int rsp_wait;
    int last_row;
    int last_col;
    int error_count;
    int replies_checked;
    int border_settings;
    int cmd_tally [8];

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #50ms;
        $display("[shape_raster_framebuffer] ERROR");
        $finish;
    end

    function automatic logic [FLD_W-1:0] clamp_coord(input int v, input int hi);
        if (v < 0) return '0;
        if (v > hi) return FLD_W'(hi);
        return FLD_W'(v);
    endfunction

    function automatic int draw_gap();
        if (no_idle) return 0;
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic logic paint_frame(input int r0, c0, r1, c1,
                                         input logic [PIX_W-1:0] rgb);
        int bw;
        bw = int'(shadow_bw);
        if (r0 >= FRAME_HEIGHT || r1 >= FRAME_HEIGHT || c0 >= FRAME_WIDTH || c1 >= FRAME_WIDTH)
            return 1'b1;
        for (int h = r0; h <= r1; h++) begin
            for (int c = c0; c <= c1; c++) begin
                if (c < c0 + bw || c > c1 - bw || h < r0 + bw || h > r1 - bw)
                    shadow_fb[h * FRAME_WIDTH + c] = rgb;
            end
        end
        return 1'b0;
    endfunction

    function automatic void paint_disc(input int cr, cc, rad, input logic [PIX_W-1:0] rgb);
        if (rad <= 0) return;
        for (int h = cr - rad; h <= cr + rad; h++) begin
            for (int c = cc - rad; c <= cc + rad; c++) begin
                if ((h - cr) * (h - cr) + (c - cc) * (c - cc) < rad * rad)
                    shadow_fb[h * FRAME_WIDTH + c] = rgb;
            end
        end
    endfunction

    function automatic t_pixel_reply predict_reply(input t_req req);
        t_pixel_reply reply;
        logic [PIX_W-1:0] px;
        int r, c, rad;
        reply = '0;
        px = '0;
        r = int'(req.row);
        c = int'(req.col);
        rad = int'(req.radius);
        case (req.cmd)
            CMD_FILL: begin
                foreach (shadow_fb[i]) shadow_fb[i] = req.color;
            end
            CMD_RECT: begin
                reply.status = paint_frame(r, c, int'(req.row_end), int'(req.col_end),
                                           req.color);
            end
            CMD_DISC, CMD_RING: begin
                if (r - rad < 0 || c - rad < 0 || r + rad >= FRAME_HEIGHT
                        || c + rad >= FRAME_WIDTH) begin
                    reply.status = 1'b1;
                end else begin
                    paint_disc(r, c, rad, req.color);
                    if (req.cmd == CMD_RING)
                        paint_disc(r, c, rad - int'(req.ring_width), PIX_BLACK);
                end
            end
            CMD_READ: begin
                if (r >= FRAME_HEIGHT || c >= FRAME_WIDTH)
                    reply.status = 1'b1;
                else
                    px = shadow_fb[r * FRAME_WIDTH + c];
            end
            default: begin
            end
        endcase
        reply.red = px[2*CH_W +: CH_W];
        reply.green = px[CH_W +: CH_W];
        reply.blue = px[0 +: CH_W];
        return reply;
    endfunction

    function automatic t_req random_command();
        t_req req;
        int pick, rad, off;
        req = $bits(t_req)'({$urandom, $urandom, $urandom});
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            req.cmd = CMD_READ;
            off = $urandom_range(0, 24);
            req.row = clamp_coord(last_row + off - 8, FRAME_HEIGHT - 1);
            off = $urandom_range(0, 24);
            req.col = clamp_coord(last_col + off - 8, FRAME_WIDTH - 1);
        end else if (pick < 50) begin
            req.cmd = CMD_RECT;
            req.row = FLD_W'($urandom_range(0, FRAME_HEIGHT - 1));
            req.col = FLD_W'($urandom_range(0, FRAME_WIDTH - 1));
            req.row_end = clamp_coord(req.row + $urandom_range(0, 31), FRAME_HEIGHT - 1);
            req.col_end = clamp_coord(req.col + $urandom_range(0, 31), FRAME_WIDTH - 1);
            last_row = int'(req.row);
            last_col = int'(req.col);
        end else if (pick < 85) begin
            req.cmd = (pick < 68) ? CMD_DISC : CMD_RING;
            rad = $urandom_range(0, 12);
            req.radius = FLD_W'(rad);
            req.row = FLD_W'($urandom_range(rad, FRAME_HEIGHT - 1 - rad));
            req.col = FLD_W'($urandom_range(rad, FRAME_WIDTH - 1 - rad));
            if ($urandom_range(0, 9) < 7)
                req.ring_width = FLD_W'($urandom_range(0, rad + 2));
            last_row = int'(req.row) - 4;
            last_col = int'(req.col) - 4;
        end else if (pick < 90) begin
            req.cmd = CMD_READ;
        end else begin
            case ($urandom_range(0, 4))
                0: begin
                    req.cmd = CMD_RECT;
                    req.row = FLD_W'($urandom_range(0, FRAME_HEIGHT - 1));
                    req.col = FLD_W'($urandom_range(0, FRAME_WIDTH - 1));
                    req.row_end = clamp_coord(req.row + $urandom_range(0, 31), FRAME_HEIGHT - 1);
                    req.col_end = clamp_coord(req.col + $urandom_range(0, 31), FRAME_WIDTH - 1);
                    case ($urandom_range(0, 3))
                        0: req.row = FLD_W'($urandom_range(FRAME_HEIGHT, FLD_MAX));
                        1: req.row_end = FLD_W'($urandom_range(FRAME_HEIGHT, FLD_MAX));
                        2: req.col = FLD_W'($urandom_range(FRAME_WIDTH, FLD_MAX));
                        default: req.col_end = FLD_W'($urandom_range(FRAME_WIDTH, FLD_MAX));
                    endcase
                end
                1: begin
                    req.cmd = CMD_RECT;
                    req.row_end = FLD_W'($urandom_range(0, FRAME_HEIGHT - 2));
                    req.row = clamp_coord(req.row_end + $urandom_range(1, 8), FRAME_HEIGHT - 1);
                    req.col = FLD_W'($urandom_range(0, FRAME_WIDTH - 9));
                    req.col_end = FLD_W'(req.col + $urandom_range(0, 8));
                    if ($urandom_range(0, 1) == 1)
                        {req.col, req.col_end} = {req.col_end, req.col};
                end
                2: begin
                    req.cmd = ($urandom_range(0, 1) == 1) ? CMD_DISC : CMD_RING;
                    req.radius = FLD_W'($urandom_range(FRAME_HEIGHT / 2, FLD_MAX));
                end
                3: begin
                    req.cmd = ($urandom_range(0, 1) == 1) ? CMD_DISC : CMD_RING;
                    rad = $urandom_range(1, 12);
                    req.radius = FLD_W'(rad);
                    req.row = FLD_W'($urandom_range(rad, FRAME_HEIGHT - 1 - rad));
                    req.col = FLD_W'($urandom_range(rad, FRAME_WIDTH - 1 - rad));
                    if ($urandom_range(0, 1) == 1)
                        req.row = FLD_W'($urandom_range(0, rad - 1));
                    else
                        req.col = FLD_W'(FRAME_WIDTH - 1 - $urandom_range(0, rad - 1));
                end
                default: begin
                    req.cmd = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
                end
            endcase
        end
        return req;
    endfunction

    task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input int row, col, row_end, col_end,
                             radius, ring_width, input logic [PIX_W-1:0] color);
        t_req req;
        req.cmd = cmd;
        req.row = FLD_W'(row);
        req.col = FLD_W'(col);
        req.row_end = FLD_W'(row_end);
        req.col_end = FLD_W'(col_end);
        req.radius = FLD_W'(radius);
        req.ring_width = FLD_W'(ring_width);
        req.color = color;
        command_backlog.push_back(req);
    endtask

    task automatic settle();
        while (command_backlog.size() != 0 || cmd_ch.valid || expected_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_border(input logic [BW_W-1:0] width);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= width;
        @(negedge clk);
        cfg_we <= 1'b0;
        shadow_bw = width;
        border_settings++;
    endtask

    always @(negedge clk) begin
        if (!rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else if (cmd_taken || !cmd_ch.valid) begin
            if (send_wait > 0) begin
                send_wait--;
                cmd_ch.valid <= 1'b0;
            end else if (command_backlog.size() != 0) begin
                next_cmd = command_backlog.pop_front();
                cmd_ch.valid <= 1'b1;
                cmd_ch.cmd <= next_cmd.cmd;
                cmd_ch.row <= next_cmd.row;
                cmd_ch.col <= next_cmd.col;
                cmd_ch.row_end <= next_cmd.row_end;
                cmd_ch.col_end <= next_cmd.col_end;
                cmd_ch.radius <= next_cmd.radius;
                cmd_ch.ring_width <= next_cmd.ring_width;
                cmd_ch.color <= next_cmd.color;
                send_wait = draw_gap();
            end else begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        if (rsp_taken) rsp_wait = draw_gap();
        if (stall_request) begin
            rsp_wait = STALL_CYCLES;
            stall_request = 1'b0;
        end
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (rsp_wait > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_wait--;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        cmd_taken = rst_n && cmd_ch.valid && cmd_ch.ready;
        if (cmd_taken) begin
            seen_cmd.cmd = cmd_ch.cmd;
            seen_cmd.row = cmd_ch.row;
            seen_cmd.col = cmd_ch.col;
            seen_cmd.row_end = cmd_ch.row_end;
            seen_cmd.col_end = cmd_ch.col_end;
            seen_cmd.radius = cmd_ch.radius;
            seen_cmd.ring_width = cmd_ch.ring_width;
            seen_cmd.color = cmd_ch.color;
            expected_replies.push_back(predict_reply(seen_cmd));
            cmd_tally[seen_cmd.cmd]++;
        end
    end

    always @(posedge clk) begin
        rsp_taken = rst_n && rsp_ch.valid && rsp_ch.ready;
        if (rsp_taken) begin
            if (expected_replies.size() == 0) begin
                $error("Reply item arrived with no command outstanding.");
                error_count++;
            end else begin
                want = expected_replies.pop_front();
                replies_checked++;
                if (rsp_ch.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    error_count++;
                end
                if (rsp_ch.red !== want.red) begin
                    $error("red: expected 0x%02h, got 0x%02h", want.red, rsp_ch.red);
                    error_count++;
                end
                if (rsp_ch.green !== want.green) begin
                    $error("green: expected 0x%02h, got 0x%02h", want.green, rsp_ch.green);
                    error_count++;
                end
                if (rsp_ch.blue !== want.blue) begin
                    $error("blue: expected 0x%02h, got 0x%02h", want.blue, rsp_ch.blue);
                    error_count++;
                end
            end
        end
    end

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.cmd = '0;
        cmd_ch.row = '0;
        cmd_ch.col = '0;
        cmd_ch.row_end = '0;
        cmd_ch.col_end = '0;
        cmd_ch.radius = '0;
        cmd_ch.ring_width = '0;
        cmd_ch.color = '0;
        rsp_ch.ready = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The store must read back black after the clearing pass.
        queue_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0);
        queue_cmd(CMD_READ, FRAME_HEIGHT - 1, FRAME_WIDTH - 1, 0, 0, 0, 0, 0);
        queue_cmd(CMD_READ, FRAME_HEIGHT, 0, 0, 0, 0, 0, 0);
        queue_cmd(CMD_READ, 0, FLD_MAX, 0, 0, 0, 0, 0);
        queue_cmd(CMD_FILL, 0, 0, 0, 0, 0, 0, 24'hFFFFFF);
        queue_cmd(CMD_RECT, 10, 10, 20, 30, 0, 0, 24'h00FF00);
        queue_cmd(CMD_READ, 10, 15, 0, 0, 0, 0, 0);
        queue_cmd(CMD_READ, 15, 20, 0, 0, 0, 0, 0);
        queue_cmd(CMD_RECT, 590, 790, FRAME_HEIGHT - 1, FRAME_WIDTH - 1, 0, 0, 24'h0000FF);
        queue_cmd(CMD_READ, FRAME_HEIGHT - 1, FRAME_WIDTH - 1, 0, 0, 0, 0, 0);
        queue_cmd(CMD_RECT, 0, 0, 0, 0, 0, 0, 24'h123456);
        queue_cmd(CMD_RECT, 50, 60, 40, 70, 0, 0, 24'h654321);
        queue_cmd(CMD_RECT, 0, 0, FRAME_HEIGHT, 10, 0, 0, 24'h00FF00);
        queue_cmd(CMD_DISC, 100, 100, 0, 0, 5, 0, 24'hFF0000);
        queue_cmd(CMD_READ, 100, 100, 0, 0, 0, 0, 0);
        queue_cmd(CMD_READ, 100, 105, 0, 0, 0, 0, 0);
        queue_cmd(CMD_DISC, 150, 150, 0, 0, 0, 0, 24'h00FF00);
        queue_cmd(CMD_DISC, 3, 50, 0, 0, 5, 0, 24'h00FF00);
        queue_cmd(CMD_DISC, 300, 400, 0, 0, FLD_MAX, 0, 24'h00FF00);
        queue_cmd(CMD_RING, 200, 200, 0, 0, 8, 3, 24'h808080);
        queue_cmd(CMD_READ, 200, 200, 0, 0, 0, 0, 0);
        queue_cmd(CMD_READ, 200, 206, 0, 0, 0, 0, 0);
        queue_cmd(CMD_RING, 250, 250, 0, 0, 4, 10, 24'h0000FF);
        queue_cmd(CMD_RING, 260, 260, 0, 0, 4, 0, 24'h0000FF);
        queue_cmd(CMD_DISC, 10, 10, 0, 0, 10, 0, 24'h00FF00);
        queue_cmd(CMD_RING, FRAME_HEIGHT - 11, FRAME_WIDTH - 11, 0, 0, 10, 4, 24'hFF0000);
        queue_cmd(CMD_SPARE_FIRST, 1, 1, 2, 2, 3, 1, 24'h00FF00);
        queue_cmd(CMD_SPARE_LAST, 1, 1, 2, 2, 3, 1, 24'h00FF00);
        settle();

        foreach (BORDER_PLAN[i]) begin
            write_border(BORDER_PLAN[i]);
            no_idle = (i == 1 || i == 2);
            // Hold the output long enough for the input side to back up.
            if (i == 2) stall_request = 1'b1;
            repeat (RANDOM_PER_PHASE) command_backlog.push_back(random_command());
            settle();
        end
        no_idle = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d replies: %0d fills, %0d frames, %0d discs, %0d rings, %0d reads.",
                 replies_checked, cmd_tally[CMD_FILL], cmd_tally[CMD_RECT],
                 cmd_tally[CMD_DISC], cmd_tally[CMD_RING], cmd_tally[CMD_READ]);
        $display("Unused codes: %0d; border widths written: %0d; one %0d-cycle output stall.",
                 cmd_tally[CMD_SPARE_FIRST] + cmd_tally[CMD_SPARE_FIRST + 1]
                 + cmd_tally[CMD_SPARE_LAST], border_settings, STALL_CYCLES);
        if (error_count == 0)
            $display("[shape_raster_framebuffer] OK");
        else
            $display("[shape_raster_framebuffer] ERROR");
        $finish;
    end
endmodule
